### design/nmi_pkg.sv
// Shared constants and helpers for the normal-matrix inverse pipeline.
// Used by nmi_div, nmi_sqrt and normal_matrix_inverse_3x3; no dependencies.
package nmi_pkg;

  localparam int FRAC_BITS = 16;
  localparam int SHIFT2F   = 2 * FRAC_BITS;

  localparam int IN_W   = 32;
  localparam int PROD_W = 64;
  localparam int COF_W  = 65;
  localparam int CMAG_W = 64;
  localparam int DET_W  = 97;

  // Rounding divider: numerator magnitude, denominator magnitude, quotient bits
  localparam int NUM_W   = CMAG_W + SHIFT2F;
  localparam int DEN_W   = DET_W;
  localparam int B_W     = DEN_W + 1;
  localparam int QB      = 33;
  localparam int A_W     = ((NUM_W > DEN_W) ? NUM_W : DEN_W) + 2;
  localparam int REM_W   = (A_W > B_W + QB) ? A_W : B_W + QB;
  localparam int DIV_LAT = QB + 2;

  // Square root of (s << 2F), s below 2^64
  localparam int SQ_IN_W = 64;
  localparam int SQ_X_W  = SQ_IN_W + SHIFT2F;
  localparam int SQ_R_W  = SQ_IN_W / 2 + FRAC_BITS;
  localparam int SQ_LAT  = SQ_R_W + 1;

  // Clamp a sign and magnitude to the signed 32-bit range
  function automatic logic signed [31:0] sat_signed(input logic neg, input logic [63:0] mag);
    logic signed [31:0] res;
    if (!neg) begin
      res = (mag > 64'h0000_0000_7FFF_FFFF) ? 32'sh7FFF_FFFF : $signed(mag[31:0]);
    end else begin
      res = (mag >= 64'h0000_0000_8000_0000) ? 32'sh8000_0000 : -$signed(mag[31:0]);
    end
    return res;
  endfunction

endpackage

### design/nmi_div.sv
// Pipelined rounding divider: one quotient bit per stage, saturated signed result.
// Depends on nmi_pkg.
module nmi_div (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  input  logic                              in_neg,
  input  logic [nmi_pkg::NUM_W-1:0]         in_num,
  input  logic [nmi_pkg::DEN_W-1:0]         in_den,
  output logic                              out_valid,
  output logic signed [31:0]                out_quo
);

  logic [nmi_pkg::REM_W-1:0] rem_r   [nmi_pkg::QB+1];
  logic [nmi_pkg::REM_W-1:0] rem_nxt [nmi_pkg::QB+1];
  logic [nmi_pkg::B_W-1:0]   den_r   [nmi_pkg::QB+1];
  logic [nmi_pkg::QB-1:0]    quo_r   [nmi_pkg::QB+1];
  logic [nmi_pkg::QB-1:0]    quo_nxt [nmi_pkg::QB+1];
  logic                      neg_r   [nmi_pkg::QB+1];
  logic                      ovf_r   [nmi_pkg::QB+1];
  logic                      vld_r   [nmi_pkg::QB+1];
  logic [nmi_pkg::B_W-1:0]   b_w;
  logic                      ovf_nxt;
  logic                      out_vld_r;
  logic signed [31:0]        out_quo_r;

  // Quotient = (2n + d) / 2d; overflow when it needs more than QB bits
  always_comb begin
    b_w        = {in_den, 1'b0};
    rem_nxt[0] = (nmi_pkg::REM_W'(in_num) << 1) + nmi_pkg::REM_W'(in_den);
    ovf_nxt    = rem_nxt[0] >= (nmi_pkg::REM_W'(b_w) << nmi_pkg::QB);
    quo_nxt[0] = '0;
    for (int p = 1; p <= nmi_pkg::QB; p++) begin
      rem_nxt[p] = rem_r[p-1];
      quo_nxt[p] = quo_r[p-1];
      if (rem_r[p-1] >= (nmi_pkg::REM_W'(den_r[p-1]) << (nmi_pkg::QB - p))) begin
        rem_nxt[p] = rem_r[p-1] - (nmi_pkg::REM_W'(den_r[p-1]) << (nmi_pkg::QB - p));
        quo_nxt[p][nmi_pkg::QB-p] = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int p = 0; p <= nmi_pkg::QB; p++) vld_r[p] <= 1'b0;
      out_vld_r <= 1'b0;
    end else begin
      vld_r[0] <= in_valid;
      for (int p = 1; p <= nmi_pkg::QB; p++) vld_r[p] <= vld_r[p-1];
      out_vld_r <= vld_r[nmi_pkg::QB];
    end
  end

  always_ff @(posedge clk) begin
    den_r[0] <= b_w;
    neg_r[0] <= in_neg;
    ovf_r[0] <= ovf_nxt;
    for (int p = 0; p <= nmi_pkg::QB; p++) begin
      rem_r[p] <= rem_nxt[p];
      quo_r[p] <= quo_nxt[p];
    end
    for (int p = 1; p <= nmi_pkg::QB; p++) begin
      den_r[p] <= den_r[p-1];
      neg_r[p] <= neg_r[p-1];
      ovf_r[p] <= ovf_r[p-1];
    end
    out_quo_r <= nmi_pkg::sat_signed(neg_r[nmi_pkg::QB],
                   ovf_r[nmi_pkg::QB] ? {64{1'b1}} : 64'(quo_r[nmi_pkg::QB]));
  end

  assign out_valid = out_vld_r;
  assign out_quo   = out_quo_r;

endmodule

### design/nmi_sqrt.sv
// Pipelined integer square root of (s << 2F), one root bit per stage.
// Depends on nmi_pkg.
module nmi_sqrt (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  input  logic [nmi_pkg::SQ_IN_W-1:0]   in_s,
  output logic                          out_valid,
  output logic [nmi_pkg::SQ_R_W-1:0]    out_root
);

  logic [nmi_pkg::SQ_X_W-1:0] rem_r    [nmi_pkg::SQ_R_W+1];
  logic [nmi_pkg::SQ_X_W-1:0] rem_nxt  [nmi_pkg::SQ_R_W+1];
  logic [nmi_pkg::SQ_R_W-1:0] root_r   [nmi_pkg::SQ_R_W+1];
  logic [nmi_pkg::SQ_R_W-1:0] root_nxt [nmi_pkg::SQ_R_W+1];
  logic [nmi_pkg::SQ_X_W:0]   trial    [nmi_pkg::SQ_R_W+1];
  logic                       vld_r    [nmi_pkg::SQ_R_W+1];

  // Remainder is x - root^2; setting bit j adds (root << (j+1)) + 2^(2j)
  always_comb begin
    rem_nxt[0]  = nmi_pkg::SQ_X_W'(in_s) << nmi_pkg::SHIFT2F;
    root_nxt[0] = '0;
    trial[0]    = '0;
    for (int p = 1; p <= nmi_pkg::SQ_R_W; p++) begin
      trial[p] = ((nmi_pkg::SQ_X_W+1)'(root_r[p-1]) << (nmi_pkg::SQ_R_W - p + 1))
               + (((nmi_pkg::SQ_X_W+1)'(1)) << (2 * (nmi_pkg::SQ_R_W - p)));
      rem_nxt[p]  = rem_r[p-1];
      root_nxt[p] = root_r[p-1];
      if ({1'b0, rem_r[p-1]} >= trial[p]) begin
        rem_nxt[p] = rem_r[p-1] - trial[p][nmi_pkg::SQ_X_W-1:0];
        root_nxt[p][nmi_pkg::SQ_R_W-p] = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int p = 0; p <= nmi_pkg::SQ_R_W; p++) vld_r[p] <= 1'b0;
    end else begin
      vld_r[0] <= in_valid;
      for (int p = 1; p <= nmi_pkg::SQ_R_W; p++) vld_r[p] <= vld_r[p-1];
    end
  end

  always_ff @(posedge clk) begin
    for (int p = 0; p <= nmi_pkg::SQ_R_W; p++) begin
      rem_r[p]  <= rem_nxt[p];
      root_r[p] <= root_nxt[p];
    end
  end

  assign out_valid = vld_r[nmi_pkg::SQ_R_W];
  assign out_root  = root_r[nmi_pkg::SQ_R_W];

endmodule

### design/normal_matrix_inverse_3x3.sv
// Top level: 3x3 normal matrix (transposed inverse) with optional row-2 rescale.
// Depends on nmi_pkg, nmi_div and nmi_sqrt.
//
//   channel  | ports                                  | handshake
//   ---------+----------------------------------------+---------------------------
//   request  | start, busy, in_r0c0 .. in_r2c2        | taken when start && !busy
//   result   | out_valid, out_r0c0 .. out_r2c2,       | one-cycle strobe, no hold
//            | out_is_singular                        |
//   config   | cfg_we, cfg_wdata                      | written when cfg_we
//
// Fully pipelined: one request per cycle, busy stays low. The pipe holds the two
// bit-per-stage dividers (35 stages each) and the bit-per-stage square root
// (49 stages). Synchronous active-low reset clears only the valid bits and the
// config register. The receiver cannot stall, so nothing in the pipe ever holds.
module normal_matrix_inverse_3x3 (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  logic signed [31:0] in_r0c0,
  input  logic signed [31:0] in_r0c1,
  input  logic signed [31:0] in_r0c2,
  input  logic signed [31:0] in_r1c0,
  input  logic signed [31:0] in_r1c1,
  input  logic signed [31:0] in_r1c2,
  input  logic signed [31:0] in_r2c0,
  input  logic signed [31:0] in_r2c1,
  input  logic signed [31:0] in_r2c2,
  input  logic               cfg_we,
  input  logic               cfg_wdata,
  output logic               out_valid,
  output logic signed [31:0] out_r0c0,
  output logic signed [31:0] out_r0c1,
  output logic signed [31:0] out_r0c2,
  output logic signed [31:0] out_r1c0,
  output logic signed [31:0] out_r1c1,
  output logic signed [31:0] out_r1c2,
  output logic signed [31:0] out_r2c0,
  output logic signed [31:0] out_r2c1,
  output logic signed [31:0] out_r2c2,
  output logic               out_is_singular
);

  // Minor operand indices: cofactor k = ad - bc, negated on odd k
  localparam int PA [9] = '{4, 3, 3, 1, 0, 0, 1, 0, 0};
  localparam int PD [9] = '{8, 8, 7, 8, 8, 7, 5, 5, 4};
  localparam int PB [9] = '{5, 5, 4, 2, 2, 1, 2, 2, 1};
  localparam int PC [9] = '{7, 6, 6, 7, 6, 6, 4, 3, 3};

  // Sideband carried alongside the long units
  typedef struct packed {
    logic             sing;
    logic             rsc;
    logic [8:0][31:0] sres;
  } side_a_t;

  typedef struct packed {
    logic             sing;
    logic             rsc;
    logic [8:0][31:0] r;
  } side_b_t;

  typedef struct packed {
    logic             sing;
    logic             apply;
    logic [8:0][31:0] r;
  } side_c_t;

  logic                                   rescale_r;
  logic                                   v_a_r, v_b_r, v_c_r, v_d_r, v_e_r, v_f_r, v_g_r;
  logic                                   v_h_r, v_i_r, v_j_r, out_vld_r;

  logic signed [31:0]                     m_in [9];
  logic signed [31:0]                     m_r  [9];
  logic                                   rsc_a_r, rsc_b_r, rsc_c_r, rsc_d_r, rsc_e_r;
  logic                                   rsc_f_r, rsc_g_r;
  logic signed [nmi_pkg::PROD_W-1:0]      prod_ad_r [9];
  logic signed [nmi_pkg::PROD_W-1:0]      prod_bc_r [9];
  logic signed [31:0]                     row_b_r [3];
  logic signed [31:0]                     row_c_r [3];
  logic signed [nmi_pkg::COF_W-1:0]       cof_c_r [9];
  logic signed [nmi_pkg::COF_W-1:0]       cof_d_r [9];
  logic signed [nmi_pkg::COF_W-1:0]       cof_e_r [9];
  logic signed [nmi_pkg::COF_W-1:0]       plo_d_r [3];
  logic signed [nmi_pkg::COF_W-1:0]       phi_d_r [3];
  logic signed [nmi_pkg::DET_W-1:0]       term_e_r [3];
  logic signed [nmi_pkg::DET_W-1:0]       det_f_r;
  logic [nmi_pkg::CMAG_W-1:0]             cmag_f_r [9];
  logic                                   cneg_f_r [9];
  logic [nmi_pkg::CMAG_W-1:0]             cmag_g_r [9];
  logic                                   cneg_g_r [9];
  logic [nmi_pkg::DEN_W-1:0]              dmag_g_r;
  logic                                   dneg_g_r;
  logic                                   sing_g_r;
  logic [8:0][31:0]                       sres_g_r;
  logic [nmi_pkg::COF_W:0]                rnd_w [9];

  side_a_t                                sa_r [nmi_pkg::DIV_LAT];
  side_a_t                                sa_out;
  logic signed [31:0]                     q1_w [9];
  logic                                   d1_vld_w [9];

  logic signed [31:0]                     r_h_r [9];
  logic                                   sing_h_r, rsc_h_r;
  logic [nmi_pkg::SQ_IN_W-1:0]            sq_i_r [3];
  logic [nmi_pkg::SQ_IN_W-1:0]            s_j_r;
  logic                                   skip_j_r;
  logic [nmi_pkg::SQ_IN_W-1:0]            s_sum_w;

  side_b_t                                sb_r [nmi_pkg::SQ_LAT+2];
  side_b_t                                sb_out;
  logic                                   skd_r [nmi_pkg::SQ_LAT];
  logic                                   sq_vld_w;
  logic [nmi_pkg::SQ_R_W-1:0]             root_w;

  side_c_t                                sc_r [nmi_pkg::DIV_LAT];
  side_c_t                                sc_out;
  logic signed [31:0]                     q2_w [9];
  logic                                   d2_vld_w [9];
  logic [31:0]                            rmag_w [9];

  logic signed [31:0]                     out_r [9];
  logic                                   out_sing_r;

  assign busy = 1'b0;

  always_comb begin
    m_in[0] = in_r0c0; m_in[1] = in_r0c1; m_in[2] = in_r0c2;
    m_in[3] = in_r1c0; m_in[4] = in_r1c1; m_in[5] = in_r1c2;
    m_in[6] = in_r2c0; m_in[7] = in_r2c1; m_in[8] = in_r2c2;
  end

  // Control: config register and stage valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rescale_r <= 1'b0;
      v_a_r <= 1'b0; v_b_r <= 1'b0; v_c_r <= 1'b0; v_d_r <= 1'b0;
      v_e_r <= 1'b0; v_f_r <= 1'b0; v_g_r <= 1'b0;
      v_h_r <= 1'b0; v_i_r <= 1'b0; v_j_r <= 1'b0;
      out_vld_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        rescale_r <= cfg_wdata;
      end
      v_a_r <= start && !busy;
      v_b_r <= v_a_r; v_c_r <= v_b_r; v_d_r <= v_c_r;
      v_e_r <= v_d_r; v_f_r <= v_e_r; v_g_r <= v_f_r;
      v_h_r <= d1_vld_w[0];
      v_i_r <= v_h_r;
      v_j_r <= v_i_r;
      out_vld_r <= d2_vld_w[0];
    end
  end

  // Front end: capture, minor products, cofactors, determinant
  always_comb begin
    for (int k = 0; k < 9; k++) begin
      rnd_w[k] = ((nmi_pkg::COF_W+1)'(cmag_f_r[k]) + ((nmi_pkg::COF_W+1)'(1) << (nmi_pkg::FRAC_BITS-1)))
               >> nmi_pkg::FRAC_BITS;
    end
  end

  always_ff @(posedge clk) begin
    // Stage A: capture the request
    for (int k = 0; k < 9; k++) m_r[k] <= m_in[k];
    rsc_a_r <= rescale_r;

    // Stage B: the eighteen 32x32 products of the 2x2 minors
    for (int k = 0; k < 9; k++) begin
      prod_ad_r[k] <= nmi_pkg::PROD_W'(m_r[PA[k]]) * nmi_pkg::PROD_W'(m_r[PD[k]]);
      prod_bc_r[k] <= nmi_pkg::PROD_W'(m_r[PB[k]]) * nmi_pkg::PROD_W'(m_r[PC[k]]);
    end
    for (int j = 0; j < 3; j++) row_b_r[j] <= m_r[j];
    rsc_b_r <= rsc_a_r;

    // Stage C: exact signed cofactors
    for (int k = 0; k < 9; k++) begin
      if (k % 2 == 1) begin
        cof_c_r[k] <= nmi_pkg::COF_W'(prod_bc_r[k]) - nmi_pkg::COF_W'(prod_ad_r[k]);
      end else begin
        cof_c_r[k] <= nmi_pkg::COF_W'(prod_ad_r[k]) - nmi_pkg::COF_W'(prod_bc_r[k]);
      end
    end
    row_c_r <= row_b_r;
    rsc_c_r <= rsc_b_r;

    // Stage D: row-0 cofactor times row-0 entry, split in two halves
    for (int j = 0; j < 3; j++) begin
      plo_d_r[j] <= nmi_pkg::COF_W'($signed({1'b0, cof_c_r[j][31:0]}))
                  * nmi_pkg::COF_W'(row_c_r[j]);
      phi_d_r[j] <= nmi_pkg::COF_W'($signed(cof_c_r[j][nmi_pkg::COF_W-1:32]))
                  * nmi_pkg::COF_W'(row_c_r[j]);
    end
    cof_d_r <= cof_c_r;
    rsc_d_r <= rsc_c_r;

    // Stage E: recombine the halves
    for (int j = 0; j < 3; j++) begin
      term_e_r[j] <= (nmi_pkg::DET_W'(phi_d_r[j]) <<< 32) + nmi_pkg::DET_W'(plo_d_r[j]);
    end
    cof_e_r <= cof_d_r;
    rsc_e_r <= rsc_d_r;

    // Stage F: determinant; cofactor sign and magnitude
    det_f_r <= term_e_r[0] + term_e_r[1] + term_e_r[2];
    for (int k = 0; k < 9; k++) begin
      cneg_f_r[k] <= cof_e_r[k][nmi_pkg::COF_W-1];
      cmag_f_r[k] <= cof_e_r[k][nmi_pkg::COF_W-1] ? nmi_pkg::CMAG_W'(-cof_e_r[k])
                                                  : nmi_pkg::CMAG_W'(cof_e_r[k]);
    end
    rsc_f_r <= rsc_e_r;

    // Stage G: determinant magnitude, zero test, rounded raw cofactors
    dneg_g_r <= det_f_r[nmi_pkg::DET_W-1];
    dmag_g_r <= det_f_r[nmi_pkg::DET_W-1] ? nmi_pkg::DEN_W'(-det_f_r)
                                          : nmi_pkg::DEN_W'(det_f_r);
    sing_g_r <= (det_f_r == '0);
    for (int k = 0; k < 9; k++) begin
      sres_g_r[k] <= nmi_pkg::sat_signed(cneg_f_r[k], rnd_w[k][63:0]);
    end
    cmag_g_r <= cmag_f_r;
    cneg_g_r <= cneg_f_r;
    rsc_g_r  <= rsc_f_r;
  end

  // Nine cofactor / determinant dividers
  for (genvar k = 0; k < 9; k++) begin : g_div1
    nmi_div u_div (
      .clk       (clk),
      .rst_n     (rst_n),
      .in_valid  (v_g_r),
      .in_neg    (cneg_g_r[k] ^ dneg_g_r),
      .in_num    (nmi_pkg::NUM_W'(cmag_g_r[k]) << nmi_pkg::SHIFT2F),
      .in_den    (dmag_g_r),
      .out_valid (d1_vld_w[k]),
      .out_quo   (q1_w[k])
    );
  end

  assign sa_out = sa_r[nmi_pkg::DIV_LAT-1];

  // Row-2 length: squares, sum, then the root unit
  always_comb begin
    s_sum_w = sq_i_r[0] + sq_i_r[1] + sq_i_r[2];
  end

  always_ff @(posedge clk) begin
    // Hold singular flag and raw cofactors across the divider
    sa_r[0] <= '{sing: sing_g_r, rsc: rsc_g_r, sres: sres_g_r};
    for (int i = 1; i < nmi_pkg::DIV_LAT; i++) sa_r[i] <= sa_r[i-1];

    // Stage H: pick quotient or raw cofactor; rescale only when non-singular
    for (int k = 0; k < 9; k++) begin
      r_h_r[k] <= sa_out.sing ? $signed(sa_out.sres[k]) : q1_w[k];
    end
    sing_h_r <= sa_out.sing;
    rsc_h_r  <= sa_out.rsc && !sa_out.sing;

    // Stage I: squares of row 2
    for (int j = 0; j < 3; j++) begin
      sq_i_r[j] <= nmi_pkg::SQ_IN_W'(nmi_pkg::SQ_IN_W'(r_h_r[6+j])
                 * nmi_pkg::SQ_IN_W'(r_h_r[6+j]));
    end

    // Stage J: squared length; skip when zero or exactly one
    s_j_r    <= s_sum_w;
    skip_j_r <= (s_sum_w == '0) ||
                (s_sum_w == (nmi_pkg::SQ_IN_W'(1) << nmi_pkg::SHIFT2F));

    // Hold the matrix until the root is ready
    sb_r[0].sing <= sing_h_r;
    sb_r[0].rsc  <= rsc_h_r;
    for (int k = 0; k < 9; k++) sb_r[0].r[k] <= r_h_r[k];
    for (int i = 1; i < nmi_pkg::SQ_LAT + 2; i++) sb_r[i] <= sb_r[i-1];

    skd_r[0] <= skip_j_r;
    for (int i = 1; i < nmi_pkg::SQ_LAT; i++) skd_r[i] <= skd_r[i-1];
  end

  nmi_sqrt u_sqrt (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (v_j_r),
    .in_s      (s_j_r),
    .out_valid (sq_vld_w),
    .out_root  (root_w)
  );

  assign sb_out = sb_r[nmi_pkg::SQ_LAT+1];

  // Rescale dividers: each entry over the row-2 length
  always_comb begin
    for (int k = 0; k < 9; k++) begin
      rmag_w[k] = sb_out.r[k][31] ? (32'd0 - sb_out.r[k]) : sb_out.r[k];
    end
  end

  for (genvar k = 0; k < 9; k++) begin : g_div2
    nmi_div u_div (
      .clk       (clk),
      .rst_n     (rst_n),
      .in_valid  (sq_vld_w),
      .in_neg    (sb_out.r[k][31]),
      .in_num    (nmi_pkg::NUM_W'(rmag_w[k]) << nmi_pkg::SHIFT2F),
      .in_den    (nmi_pkg::DEN_W'(root_w)),
      .out_valid (d2_vld_w[k]),
      .out_quo   (q2_w[k])
    );
  end

  assign sc_out = sc_r[nmi_pkg::DIV_LAT-1];

  always_ff @(posedge clk) begin
    sc_r[0] <= '{sing: sb_out.sing,
                 apply: sb_out.rsc && !skd_r[nmi_pkg::SQ_LAT-1],
                 r: sb_out.r};
    for (int i = 1; i < nmi_pkg::DIV_LAT; i++) sc_r[i] <= sc_r[i-1];

    // Output stage: rescaled or plain entries
    for (int k = 0; k < 9; k++) begin
      out_r[k] <= sc_out.apply ? q2_w[k] : $signed(sc_out.r[k]);
    end
    out_sing_r <= sc_out.sing;
  end

  assign out_valid       = out_vld_r;
  assign out_is_singular = out_sing_r;
  assign out_r0c0 = out_r[0];
  assign out_r0c1 = out_r[1];
  assign out_r0c2 = out_r[2];
  assign out_r1c0 = out_r[3];
  assign out_r1c1 = out_r[4];
  assign out_r1c2 = out_r[5];
  assign out_r2c0 = out_r[6];
  assign out_r2c1 = out_r[7];
  assign out_r2c2 = out_r[8];

endmodule
